@@ src/sap_pkg.sv @@
// ----------------------------------------------------------------------------
// sap_pkg
// Shared constants, CORDIC table and register index codes for the solar
// altitude/azimuth pipeline.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int DEF_CORDIC_STAGES = 16;

  // angles in 2^-16 degree
  localparam int AW = 26;
  // CORDIC datapath width, Q30 values
  localparam int QW = 34;
  // square root radicand width and step count
  localparam int RW = 62;
  localparam int SQ_STEPS = 31;

  localparam logic signed [AW-1:0] FULL_TURN    = 26'sd23592960;
  localparam logic signed [AW-1:0] HALF_TURN    = 26'sd11796480;
  localparam logic signed [AW-1:0] QUARTER_TURN = 26'sd5898240;

  localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [23:0] ATAN_TAB [32] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945,
    24'd234379,  24'd117304,  24'd58666,  24'd29335,
    24'd14668,   24'd7334,    24'd3667,   24'd1833,
    24'd917,     24'd458,     24'd229,    24'd115,
    24'd57,      24'd29,      24'd14,     24'd7,
    24'd4,       24'd2,       24'd1,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0,
    24'd0,       24'd0,       24'd0,      24'd0
  };

  localparam logic [15:0] NOON = 16'd12288;
  localparam logic signed [31:0] NEAR_ZERO = 32'sd10737;
  localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;
  localparam logic signed [20:0] AZ_FULL = 21'sd92160;
  localparam logic signed [20:0] AZ_SOUTH = 21'sd46080;
  localparam logic signed [18:0] ELEV_LIMIT = 19'sd23040;

  typedef enum logic [2:0] {
    REG_LATITUDE         = 3'd0,
    REG_DECLINATION      = 3'd1,
    REG_TURN_CLOCKWISE   = 3'd2,
    REG_AZIMUTH_OFFSET   = 3'd3,
    REG_ELEVATION_OFFSET = 3'd4
  } reg_index_t;

endpackage

@@ src/solar_altitude_azimuth.sv @@
// ----------------------------------------------------------------------------
// solar_altitude_azimuth
// Solar elevation and azimuth from local time, latitude and declination.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with hour_of_day (1/1024 hour) to hand in an item; it is taken
//   at any edge where busy is low. busy is set in reset, is cleared once reset
//   is released and stays low: an item can enter every cycle.
//   Each item gives one result: sun_elevation, sun_azimuth and
//   azimuth_fallback, shown for one cycle with done high.
//   Items pass through the two CORDIC pipelines and the two 31-step square
//   root pipelines, with registered stages between them.
//   Throughput is one item per cycle; there is no output stall.
//   Registers are to be written through cfg_we/cfg_addr/cfg_data while no item
//   is in flight; the block does not enforce this. Unknown indexes are ignored.
//   Reset clears the pipeline valids and loads the register defaults
//   (all zero, turn_clockwise one). Items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module solar_altitude_azimuth import sap_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [14:0]        hour_of_day,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [17:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] sun_elevation,
  output logic [16:0]        sun_azimuth,
  output logic               azimuth_fallback
);

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] sp;
    logic signed [31:0] sd;
    logic signed [31:0] cp;
    logic               ha_pos;
  } sq1_side_t;

  typedef struct packed {
    logic signed [31:0] nn;
    logic signed [31:0] s;
    logic signed [31:0] calt;
    logic               fb;
    logic               ha_pos;
  } sq2_side_t;

  typedef struct packed {
    logic fb;
    logic ha_pos;
  } at_side_t;

  function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  // configuration
  logic signed [15:0] latitude;
  logic signed [15:0] declination;
  logic               turn_clockwise;
  logic signed [17:0] azimuth_offset;
  logic signed [15:0] elevation_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      latitude         <= '0;
      declination      <= '0;
      turn_clockwise   <= 1'b1;
      azimuth_offset   <= '0;
      elevation_offset <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_LATITUDE:         latitude         <= cfg_data[15:0];
        REG_DECLINATION:      declination      <= cfg_data[15:0];
        REG_TURN_CLOCKWISE:   turn_clockwise   <= cfg_data[0];
        REG_AZIMUTH_OFFSET:   azimuth_offset   <= cfg_data;
        REG_ELEVATION_OFFSET: elevation_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // input register
  logic        a_valid;
  logic [14:0] a_hour;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_hour <= hour_of_day;
  end

  logic signed [15:0]   hd;
  logic signed [AW-1:0] ha;
  logic signed [AW-1:0] sc_angle [3];

  assign hd = $signed({1'b0, a_hour}) - $signed(NOON);
  assign ha = (AW'(hd) <<< 10) - (AW'(hd) <<< 6);
  assign sc_angle[0] = AW'(latitude) <<< 8;
  assign sc_angle[1] = AW'(declination) <<< 8;
  assign sc_angle[2] = ha;

  logic                 sc_valid;
  logic signed [QW-1:0] sc_sin [3];
  logic signed [QW-1:0] sc_cos [3];
  logic                 sc_ha_pos;

  sap_sincos #(.LANES(3), .STAGES(CORDIC_STAGES), .SW(1)) u_sincos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .angle    (sc_angle),
    .in_side  (hd > 0),
    .out_valid(sc_valid),
    .sin_q    (sc_sin),
    .cos_q    (sc_cos),
    .out_side (sc_ha_pos)
  );

  // sin(alt) = sp*sd + cp*cd*ch
  logic               p1_valid, p2_valid, p3_valid, p4_valid, p5_valid;
  logic signed [33:0] p1_m1, p1_m2, p2_m1, p2_m3;
  logic signed [31:0] p1_ch;
  sq1_side_t          p1_sd, p2_sd, p3_sd, p4_sd, p5_sd;
  logic signed [34:0] p3_sum;
  logic signed [63:0] p4_sq;
  logic [RW-1:0]      p5_rad;

  assign p3_sum = 35'(p2_m1) + 35'(p2_m3);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
    end else begin
      p1_valid <= sc_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
    end
    p1_m1        <= qmul(sc_sin[0][31:0], sc_sin[1][31:0]);
    p1_m2        <= qmul(sc_cos[0][31:0], sc_cos[1][31:0]);
    p1_ch        <= sc_cos[2][31:0];
    p1_sd.s      <= '0;
    p1_sd.sp     <= sc_sin[0][31:0];
    p1_sd.sd     <= sc_sin[1][31:0];
    p1_sd.cp     <= sc_cos[0][31:0];
    p1_sd.ha_pos <= sc_ha_pos;

    p2_m1 <= p1_m1;
    p2_m3 <= qmul(p1_m2[31:0], p1_ch);
    p2_sd <= p1_sd;

    p3_sd.sp     <= p2_sd.sp;
    p3_sd.sd     <= p2_sd.sd;
    p3_sd.cp     <= p2_sd.cp;
    p3_sd.ha_pos <= p2_sd.ha_pos;
    if (p3_sum > Q30_ONE) begin
      p3_sd.s <= Q30_ONE[31:0];
    end else if (p3_sum < -Q30_ONE) begin
      p3_sd.s <= -Q30_ONE[31:0];
    end else begin
      p3_sd.s <= p3_sum[31:0];
    end

    p4_sq <= p3_sd.s * p3_sd.s;
    p4_sd <= p3_sd;

    p5_rad <= (RW'(1) << 60) - p4_sq[RW-1:0];
    p5_sd  <= p4_sd;
  end

  logic                sq1_valid;
  logic [SQ_STEPS-1:0] sq1_root;
  sq1_side_t           sq1_sd;

  sap_sqrt #(.SW($bits(sq1_side_t))) u_sqrt_alt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p5_valid),
    .radicand (p5_rad),
    .in_side  (p5_sd),
    .out_valid(sq1_valid),
    .root     (sq1_root),
    .out_side (sq1_sd)
  );

  // azimuth ratio terms
  logic signed [31:0] calt;
  assign calt = $signed({1'b0, sq1_root});

  logic               d1_valid, d2_valid, d3_valid, d4_valid, d5_valid;
  logic signed [33:0] d1_t1, d1_t2;
  logic signed [31:0] d1_sd;
  logic signed [34:0] d2_num;
  logic signed [33:0] d2_den;
  logic signed [31:0] d3_nn, d3_dd;
  logic signed [63:0] d4_nn2, d4_dd2;
  logic [RW-1:0]      d5_rad;
  sq2_side_t          d1_s, d2_s, d3_s, d4_s, d5_s;
  logic signed [34:0] d_nn, d_dd;

  always_comb begin
    if (d2_den < 0) begin
      d_nn = -d2_num;
      d_dd = -35'(d2_den);
    end else begin
      d_nn = d2_num;
      d_dd = 35'(d2_den);
    end
    if (d_nn > d_dd) begin
      d_nn = d_dd;
    end else if (d_nn < -d_dd) begin
      d_nn = -d_dd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      d4_valid <= 1'b0;
      d5_valid <= 1'b0;
    end else begin
      d1_valid <= sq1_valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      d4_valid <= d3_valid;
      d5_valid <= d4_valid;
    end
    d1_t1       <= qmul(sq1_sd.sp, sq1_sd.s);
    d1_t2       <= qmul(sq1_sd.cp, calt);
    d1_sd       <= sq1_sd.sd;
    d1_s.nn     <= '0;
    d1_s.s      <= sq1_sd.s;
    d1_s.calt   <= calt;
    d1_s.fb     <= !(calt > NEAR_ZERO &&
                     (sq1_sd.cp > NEAR_ZERO || sq1_sd.cp < -NEAR_ZERO));
    d1_s.ha_pos <= sq1_sd.ha_pos;

    d2_num <= 35'(d1_sd) - 35'(d1_t1);
    d2_den <= d1_t2;
    d2_s   <= d1_s;

    d3_nn <= d_nn[31:0];
    d3_dd <= d_dd[31:0];
    d3_s  <= d2_s;

    d4_nn2      <= d3_nn * d3_nn;
    d4_dd2      <= d3_dd * d3_dd;
    d4_s.nn     <= d3_nn;
    d4_s.s      <= d3_s.s;
    d4_s.calt   <= d3_s.calt;
    d4_s.fb     <= d3_s.fb;
    d4_s.ha_pos <= d3_s.ha_pos;

    d5_rad <= d4_dd2[RW-1:0] - d4_nn2[RW-1:0];
    d5_s   <= d4_s;
  end

  logic                sq2_valid;
  logic [SQ_STEPS-1:0] sq2_root;
  sq2_side_t           sq2_s;

  sap_sqrt #(.SW($bits(sq2_side_t))) u_sqrt_az (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d5_valid),
    .radicand (d5_rad),
    .in_side  (d5_s),
    .out_valid(sq2_valid),
    .root     (sq2_root),
    .out_side (sq2_s)
  );

  // lane 0: azimuth, lane 1: altitude
  logic signed [QW-1:0] at_y [2];
  logic signed [QW-1:0] at_x [2];
  logic signed [AW-1:0] at_z [2];
  logic                 at_valid;
  at_side_t             at_in_s, at_out_s;

  assign at_y[0] = $signed({{(QW-SQ_STEPS){1'b0}}, sq2_root});
  assign at_x[0] = QW'(sq2_s.nn);
  assign at_y[1] = QW'(sq2_s.s);
  assign at_x[1] = QW'(sq2_s.calt);
  assign at_in_s.fb     = sq2_s.fb;
  assign at_in_s.ha_pos = sq2_s.ha_pos;

  sap_atan2 #(.LANES(2), .STAGES(CORDIC_STAGES), .SW($bits(at_side_t))) u_atan2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq2_valid),
    .y_in     (at_y),
    .x_in     (at_x),
    .in_side  (at_in_s),
    .out_valid(at_valid),
    .angle    (at_z),
    .out_side (at_out_s)
  );

  // output formatting
  logic               f1_valid, f2_valid, f3_valid, f4_valid;
  logic signed [AW-1:0] f1_az, f1_el;
  at_side_t           f1_s;
  logic signed [20:0] f2_az;
  logic signed [18:0] f2_el;
  logic               f2_fb, f3_fb, f4_fb;
  logic signed [20:0] f2_a1;
  logic [19:0]        f3_u, f4_u, f4_w;
  logic signed [20:0] f3_a;
  logic signed [15:0] f3_el, f4_el;
  logic signed [17:0] f1_az256, f1_el256;

  assign f1_az256 = 18'((f1_az + AW'(128)) >>> 8);
  assign f1_el256 = 18'((f1_el + AW'(128)) >>> 8);

  always_comb begin
    if (f1_s.fb) begin
      f2_a1 = AZ_SOUTH;
    end else if (f1_s.ha_pos) begin
      f2_a1 = AZ_FULL - 21'(f1_az256);
    end else begin
      f2_a1 = 21'(f1_az256);
    end
  end

  assign f3_a = f2_az + 21'(azimuth_offset) + 21'sd276480;

  always_comb begin
    f4_w = f3_u;
    if (f4_w >= 20'd368640) begin
      f4_w = f4_w - 20'd368640;
    end
    if (f4_w >= 20'd184320) begin
      f4_w = f4_w - 20'd184320;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      f1_valid <= at_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
      done     <= f4_valid;
    end
    f1_az <= at_z[0];
    f1_el <= at_z[1];
    f1_s  <= at_out_s;

    f2_az <= turn_clockwise ? f2_a1 : AZ_FULL - f2_a1;
    f2_el <= 19'(f1_el256) + 19'(elevation_offset);
    f2_fb <= f1_s.fb;

    f3_u  <= f3_a[19:0];
    f3_fb <= f2_fb;
    if (f2_el > ELEV_LIMIT) begin
      f3_el <= ELEV_LIMIT[15:0];
    end else if (f2_el < -ELEV_LIMIT) begin
      f3_el <= -ELEV_LIMIT[15:0];
    end else begin
      f3_el <= f2_el[15:0];
    end

    f4_u  <= f4_w;
    f4_el <= f3_el;
    f4_fb <= f3_fb;

    sun_elevation    <= f4_el;
    azimuth_fallback <= f4_fb;
    if (f4_u >= 20'(AZ_FULL)) begin
      sun_azimuth <= 17'(f4_u - 20'(AZ_FULL));
    end else begin
      sun_azimuth <= f4_u[16:0];
    end
  end

endmodule

@@ src/sap_sincos.sv @@
// ----------------------------------------------------------------------------
// sap_sincos
// Pipelined rotation-mode CORDIC, one iteration per stage, several lanes.
// ----------------------------------------------------------------------------
module sap_sincos import sap_pkg::*; #(
  parameter int LANES  = 3,
  parameter int STAGES = DEF_CORDIC_STAGES,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] angle [LANES],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [QW-1:0] sin_q [LANES],
  output logic signed [QW-1:0] cos_q [LANES],
  output logic [SW-1:0]        out_side
);

  logic                 vld  [STAGES+1];
  logic [SW-1:0]        side [STAGES+1];
  logic signed [QW-1:0] x    [STAGES+1][LANES];
  logic signed [QW-1:0] y    [STAGES+1][LANES];
  logic signed [AW-1:0] z    [STAGES+1][LANES];
  logic                 fl   [STAGES+1][LANES];

  logic signed [AW-1:0] red_a [LANES];
  logic                 red_f [LANES];

  // reduce to [-180,180), then fold into [-90,90]
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      red_a[l] = angle[l];
      red_f[l] = 1'b0;
      if (red_a[l] >= HALF_TURN) begin
        red_a[l] = red_a[l] - FULL_TURN;
      end else if (red_a[l] < -HALF_TURN) begin
        red_a[l] = red_a[l] + FULL_TURN;
      end
      if (red_a[l] > QUARTER_TURN) begin
        red_a[l] = red_a[l] - HALF_TURN;
        red_f[l] = 1'b1;
      end else if (red_a[l] < -QUARTER_TURN) begin
        red_a[l] = red_a[l] + HALF_TURN;
        red_f[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    side[0] <= in_side;
    for (int l = 0; l < LANES; l++) begin
      x[0][l]  <= CORDIC_GAIN;
      y[0][l]  <= '0;
      z[0][l]  <= red_a[l];
      fl[0][l] <= red_f[l];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [AW-1:0] AT = $signed(AW'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      side[i+1] <= side[i];
      for (int l = 0; l < LANES; l++) begin
        fl[i+1][l] <= fl[i][l];
        if (z[i][l] >= 0) begin
          x[i+1][l] <= x[i][l] - (y[i][l] >>> i);
          y[i+1][l] <= y[i][l] + (x[i][l] >>> i);
          z[i+1][l] <= z[i][l] - AT;
        end else begin
          x[i+1][l] <= x[i][l] + (y[i][l] >>> i);
          y[i+1][l] <= y[i][l] - (x[i][l] >>> i);
          z[i+1][l] <= z[i][l] + AT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STAGES];
    end
    out_side <= side[STAGES];
    for (int l = 0; l < LANES; l++) begin
      sin_q[l] <= fl[STAGES][l] ? -y[STAGES][l] : y[STAGES][l];
      cos_q[l] <= fl[STAGES][l] ? -x[STAGES][l] : x[STAGES][l];
    end
  end

endmodule

@@ src/sap_sqrt.sv @@
// ----------------------------------------------------------------------------
// sap_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sap_sqrt import sap_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [RW-1:0]         radicand,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [SQ_STEPS-1:0]   root,
  output logic [SW-1:0]         out_side
);

  logic          vld  [SQ_STEPS+1];
  logic [SW-1:0] side [SQ_STEPS+1];
  logic [RW-1:0] v    [SQ_STEPS+1];
  logic [RW:0]   r    [SQ_STEPS+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign v[0]    = radicand;
  assign r[0]    = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [RW:0] trial;
    assign trial = r[j] + BIT;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      side[j+1] <= side[j];
      if ({1'b0, v[j]} >= trial) begin
        v[j+1] <= v[j] - trial[RW-1:0];
        r[j+1] <= (r[j] >> 1) + BIT;
      end else begin
        v[j+1] <= v[j];
        r[j+1] <= r[j] >> 1;
      end
    end
  end

  assign out_valid = vld[SQ_STEPS];
  assign out_side  = side[SQ_STEPS];
  assign root      = r[SQ_STEPS][SQ_STEPS-1:0];

endmodule

@@ src/sap_atan2.sv @@
// ----------------------------------------------------------------------------
// sap_atan2
// Pipelined vectoring-mode CORDIC, atan2 in 2^-16 degree, several lanes.
// ----------------------------------------------------------------------------
module sap_atan2 import sap_pkg::*; #(
  parameter int LANES  = 2,
  parameter int STAGES = DEF_CORDIC_STAGES,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] y_in [LANES],
  input  logic signed [QW-1:0] x_in [LANES],
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [AW-1:0] angle [LANES],
  output logic [SW-1:0]        out_side
);

  logic                 vld  [STAGES+1];
  logic [SW-1:0]        side [STAGES+1];
  logic signed [QW-1:0] x    [STAGES+1][LANES];
  logic signed [QW-1:0] y    [STAGES+1][LANES];
  logic signed [AW-1:0] z    [STAGES+1][LANES];

  // left half plane: turn by a quarter first
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    side[0] <= in_side;
    for (int l = 0; l < LANES; l++) begin
      if (x_in[l] < 0) begin
        if (y_in[l] >= 0) begin
          x[0][l] <= y_in[l];
          y[0][l] <= -x_in[l];
          z[0][l] <= QUARTER_TURN;
        end else begin
          x[0][l] <= -y_in[l];
          y[0][l] <= x_in[l];
          z[0][l] <= -QUARTER_TURN;
        end
      end else begin
        x[0][l] <= x_in[l];
        y[0][l] <= y_in[l];
        z[0][l] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [AW-1:0] AT = $signed(AW'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      side[i+1] <= side[i];
      for (int l = 0; l < LANES; l++) begin
        if (y[i][l] > 0) begin
          x[i+1][l] <= x[i][l] + (y[i][l] >>> i);
          y[i+1][l] <= y[i][l] - (x[i][l] >>> i);
          z[i+1][l] <= z[i][l] + AT;
        end else begin
          x[i+1][l] <= x[i][l] - (y[i][l] >>> i);
          y[i+1][l] <= y[i][l] + (x[i][l] >>> i);
          z[i+1][l] <= z[i][l] - AT;
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_side  = side[STAGES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      angle[l] = z[STAGES][l];
    end
  end

endmodule
